[sv/prbq_pkg.sv]
// ----------------------------------------------------------------------------
// prbq_pkg
// Shared types and constants for the ready and blocked process queues.
// ----------------------------------------------------------------------------
package prbq_pkg;

    localparam int READY_DEPTH   = 16;
    localparam int BLOCKED_DEPTH = 16;
    localparam int ID_BITS       = 8;
    localparam int PRIORITY_BITS = 4;

    localparam int READY_CW   = $clog2(READY_DEPTH + 1);
    localparam int BLOCKED_CW = $clog2(BLOCKED_DEPTH + 1);

    // commands
    localparam logic [1:0] CMD_INS_READY   = 2'd0;
    localparam logic [1:0] CMD_INS_BLOCKED = 2'd1;
    localparam logic [1:0] CMD_REMOVE      = 2'd2;
    localparam logic [1:0] CMD_FIND        = 2'd3;

    // queue codes
    localparam logic [1:0] Q_NONE    = 2'd0;
    localparam logic [1:0] Q_READY   = 2'd1;
    localparam logic [1:0] Q_BLOCKED = 2'd2;

    // cell operations
    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD   = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_APPEND = 2'd2;
    localparam op_t OP_DROP   = 2'd3;

    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
    } entry_t;

    typedef struct packed {
        op_t                      op;
        logic                     en;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
    } ctl_t;

    typedef struct packed {
        logic                     hit;
        logic [PRIORITY_BITS-1:0] pri;
    } link_t;

endpackage

[sv/prbq_cell.sv]
// ----------------------------------------------------------------------------
// prbq_cell
// One queue slot: holds an entry, matches it against the word and shifts
// toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
module prbq_cell
    import prbq_pkg::*;
(
    input  logic   clk,
    input  logic   occ,
    input  ctl_t   ctl,
    input  logic   prev_keep,
    input  entry_t prev_entry,
    input  entry_t next_entry,
    input  link_t  link_in,
    output logic   keep,
    output entry_t entry,
    output link_t  link_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;

    assign entry = entry_reg;
    assign match = occ && (entry_reg.id == ctl.id);
    assign keep  = occ && ((ctl.op == OP_APPEND) || (entry_reg.pri >= ctl.pri));

    always_comb
    begin
        link_out.hit = link_in.hit || match;
        if (link_in.hit)
        begin
            link_out.pri = link_in.pri;
        end
        else if (match)
        begin
            link_out.pri = entry_reg.pri;
        end
        else
        begin
            link_out.pri = '0;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_INSERT, OP_APPEND:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        entry_next.id  = ctl.id;
                        entry_next.pri = ctl.pri;
                    end
                    else
                    begin
                        entry_next = prev_entry;
                    end
                end
            end
            OP_DROP:
            begin
                if (link_out.hit)
                begin
                    entry_next = next_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

[sv/process_ready_blocked_queues_top.sv]
// ----------------------------------------------------------------------------
// process_ready_blocked_queues_top
// Priority-ordered ready queue and FIFO blocked queue, each a row of cells.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   command, process_id, priority_req
//   out      output     out_valid/out_stall ok, found_queue, found_priority,
//                                           head_valid, head_id, ready_count,
//                                           blocked_count
//
// each word is first taken into the command registers; then, in the execute
// state, every cell compares against it and the row shifts in one step.
// the result waits in an output register; a new word is taken meanwhile, but
// its shift cycle waits until the pending result is taken.
// reset empties both queues at once through the fill counts.
// ----------------------------------------------------------------------------
module process_ready_blocked_queues_top
    import prbq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] process_id,
    input  logic [3:0] priority_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ok,
    output logic [1:0] found_queue,
    output logic [3:0] found_priority,
    output logic       head_valid,
    output logic [7:0] head_id,
    output logic [4:0] ready_count,
    output logic [4:0] blocked_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [1:0]               cmd_reg;
    logic [ID_BITS-1:0]       id_reg;
    logic [PRIORITY_BITS-1:0] pri_reg;

    logic [READY_CW-1:0]      ready_fill_reg;
    logic [READY_CW-1:0]      ready_fill_next;
    logic [BLOCKED_CW-1:0]    blocked_fill_reg;
    logic [BLOCKED_CW-1:0]    blocked_fill_next;

    logic                     out_valid_reg;
    logic                     ok_reg;
    logic [1:0]               fq_reg;
    logic [PRIORITY_BITS-1:0] fp_reg;
    logic                     ok_next;
    logic [1:0]               fq_next;
    logic [PRIORITY_BITS-1:0] fp_next;

    logic commit;
    logic ready_full;
    logic blocked_full;
    ctl_t r_ctl;
    ctl_t b_ctl;

    logic   [READY_DEPTH-1:0]   r_occ;
    logic   [READY_DEPTH-1:0]   r_keep;
    entry_t [READY_DEPTH-1:0]   r_entry;
    link_t  [READY_DEPTH:0]     r_link;
    logic   [BLOCKED_DEPTH-1:0] b_occ;
    logic   [BLOCKED_DEPTH-1:0] b_keep;
    entry_t [BLOCKED_DEPTH-1:0] b_entry;
    link_t  [BLOCKED_DEPTH:0]   b_link;

    assign in_stall     = (state_reg == ST_EXEC);
    assign commit       = (state_reg == ST_EXEC) && !(out_valid_reg && out_stall);
    assign ready_full   = (ready_fill_reg == READY_CW'(READY_DEPTH));
    assign blocked_full = (blocked_fill_reg == BLOCKED_CW'(BLOCKED_DEPTH));

    // cell control
    always_comb
    begin
        r_ctl.en  = commit;
        r_ctl.id  = id_reg;
        r_ctl.pri = pri_reg;
        b_ctl.en  = commit;
        b_ctl.id  = id_reg;
        b_ctl.pri = pri_reg;
        r_ctl.op  = OP_HOLD;
        b_ctl.op  = OP_HOLD;
        case (cmd_reg)
            CMD_INS_READY:
            begin
                r_ctl.op = ready_full ? OP_HOLD : OP_INSERT;
            end
            CMD_INS_BLOCKED:
            begin
                b_ctl.op = blocked_full ? OP_HOLD : OP_APPEND;
            end
            CMD_REMOVE:
            begin
                r_ctl.op = OP_DROP;
                b_ctl.op = r_link[READY_DEPTH].hit ? OP_HOLD : OP_DROP;
            end
            default:
            begin
                r_ctl.op = OP_HOLD;
                b_ctl.op = OP_HOLD;
            end
        endcase
    end

    assign r_link[0] = '0;
    assign b_link[0] = '0;

    for (genvar i = 0; i < READY_DEPTH; i++)
    begin : g_ready
        localparam logic [READY_CW-1:0] IDX = READY_CW'(i);
        assign r_occ[i] = (IDX < ready_fill_reg);
        prbq_cell u_cell
        (
            .clk        (clk),
            .occ        (r_occ[i]),
            .ctl        (r_ctl),
            .prev_keep  ((i == 0) ? 1'b1 : r_keep[(i == 0) ? 0 : i - 1]),
            .prev_entry (r_entry[(i == 0) ? 0 : i - 1]),
            .next_entry (r_entry[(i == READY_DEPTH - 1) ? i : i + 1]),
            .link_in    (r_link[i]),
            .keep       (r_keep[i]),
            .entry      (r_entry[i]),
            .link_out   (r_link[i + 1])
        );
    end

    for (genvar i = 0; i < BLOCKED_DEPTH; i++)
    begin : g_blocked
        localparam logic [BLOCKED_CW-1:0] IDX = BLOCKED_CW'(i);
        assign b_occ[i] = (IDX < blocked_fill_reg);
        prbq_cell u_cell
        (
            .clk        (clk),
            .occ        (b_occ[i]),
            .ctl        (b_ctl),
            .prev_keep  ((i == 0) ? 1'b1 : b_keep[(i == 0) ? 0 : i - 1]),
            .prev_entry (b_entry[(i == 0) ? 0 : i - 1]),
            .next_entry (b_entry[(i == BLOCKED_DEPTH - 1) ? i : i + 1]),
            .link_in    (b_link[i]),
            .keep       (b_keep[i]),
            .entry      (b_entry[i]),
            .link_out   (b_link[i + 1])
        );
    end

    // result and fill update
    always_comb
    begin
        ok_next           = 1'b0;
        fq_next           = Q_NONE;
        fp_next           = '0;
        ready_fill_next   = ready_fill_reg;
        blocked_fill_next = blocked_fill_reg;
        case (cmd_reg)
            CMD_INS_READY:
            begin
                if (!ready_full)
                begin
                    ok_next         = 1'b1;
                    fq_next         = Q_READY;
                    fp_next         = pri_reg;
                    ready_fill_next = ready_fill_reg + 1'b1;
                end
            end
            CMD_INS_BLOCKED:
            begin
                if (!blocked_full)
                begin
                    ok_next           = 1'b1;
                    fq_next           = Q_BLOCKED;
                    fp_next           = pri_reg;
                    blocked_fill_next = blocked_fill_reg + 1'b1;
                end
            end
            CMD_REMOVE, CMD_FIND:
            begin
                if (r_link[READY_DEPTH].hit)
                begin
                    ok_next = 1'b1;
                    fq_next = Q_READY;
                    fp_next = r_link[READY_DEPTH].pri;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        ready_fill_next = ready_fill_reg - 1'b1;
                    end
                end
                else if (b_link[BLOCKED_DEPTH].hit)
                begin
                    ok_next = 1'b1;
                    fq_next = Q_BLOCKED;
                    fp_next = b_link[BLOCKED_DEPTH].pri;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        blocked_fill_next = blocked_fill_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ready_fill_reg   <= '0;
            blocked_fill_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                ready_fill_reg   <= ready_fill_next;
                blocked_fill_reg <= blocked_fill_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= command;
            id_reg  <= ID_BITS'(process_id);
            pri_reg <= PRIORITY_BITS'(priority_req);
        end
        if (commit)
        begin
            ok_reg <= ok_next;
            fq_reg <= fq_next;
            fp_reg <= fp_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign found_queue    = fq_reg;
    assign found_priority = 4'(fp_reg);
    assign head_valid     = (ready_fill_reg != '0);
    assign head_id        = head_valid ? 8'(r_entry[0].id) : 8'd0;
    assign ready_count    = 5'(ready_fill_reg);
    assign blocked_count  = 5'(blocked_fill_reg);

    a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_fill_reg <= READY_CW'(READY_DEPTH))
        else $error("ready fill beyond depth");

    a_blocked_bound: assert property (@(posedge clk) disable iff (!rst_n)
        blocked_fill_reg <= BLOCKED_CW'(BLOCKED_DEPTH))
        else $error("blocked fill beyond depth");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("shift cycle left no result");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> ($stable(ready_fill_reg) && $stable(blocked_fill_reg)))
        else $error("fill changed outside a shift cycle");

endmodule

[tb/prbq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbq_checker
// Watches the command and result channels of the process queues. Keeps its
// own ready and blocked queues, predicts the result word of every accepted
// command and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module prbq_checker
    import prbq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] process_id,
    input  logic [3:0] priority_req,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       ok,
    input  logic [1:0] found_queue,
    input  logic [3:0] found_priority,
    input  logic       head_valid,
    input  logic [7:0] head_id,
    input  logic [4:0] ready_count,
    input  logic [4:0] blocked_count,
    output int         mismatches,
    output int         outstanding
);

    typedef struct {
        logic       ok;
        logic [1:0] found_queue;
        logic [3:0] found_priority;
        logic       head_valid;
        logic [7:0] head_id;
        logic [4:0] ready_count;
        logic [4:0] blocked_count;
    } queue_result_t;

    entry_t        ready_line[$];
    entry_t        blocked_line[$];
    queue_result_t owed_results[$];
    queue_result_t want;

    function automatic queue_result_t predict_command(input logic [1:0] cmd,
                                                      input logic [ID_BITS-1:0] id,
                                                      input logic [PRIORITY_BITS-1:0] pri);
        queue_result_t r;
        entry_t        e;
        int            pos;
        r.ok             = 1'b0;
        r.found_queue    = Q_NONE;
        r.found_priority = '0;
        e.id             = id;
        e.pri            = pri;
        pos              = -1;
        case (cmd)
            CMD_INS_READY:
            begin
                if (ready_line.size() < READY_DEPTH)
                begin
                    pos = 0;
                    while (pos < ready_line.size() && ready_line[pos].pri >= pri)
                        pos++;
                    ready_line.insert(pos, e);
                    r.ok             = 1'b1;
                    r.found_queue    = Q_READY;
                    r.found_priority = pri;
                end
            end
            CMD_INS_BLOCKED:
            begin
                if (blocked_line.size() < BLOCKED_DEPTH)
                begin
                    blocked_line.push_back(e);
                    r.ok             = 1'b1;
                    r.found_queue    = Q_BLOCKED;
                    r.found_priority = pri;
                end
            end
            default:
            begin
                for (int i = 0; i < ready_line.size() && pos < 0; i++)
                    if (ready_line[i].id == id)
                        pos = i;
                if (pos >= 0)
                begin
                    r.ok             = 1'b1;
                    r.found_queue    = Q_READY;
                    r.found_priority = ready_line[pos].pri;
                    if (cmd == CMD_REMOVE)
                        ready_line.delete(pos);
                end
                else
                begin
                    for (int i = 0; i < blocked_line.size() && pos < 0; i++)
                        if (blocked_line[i].id == id)
                            pos = i;
                    if (pos >= 0)
                    begin
                        r.ok             = 1'b1;
                        r.found_queue    = Q_BLOCKED;
                        r.found_priority = blocked_line[pos].pri;
                        if (cmd == CMD_REMOVE)
                            blocked_line.delete(pos);
                    end
                end
            end
        endcase
        r.head_valid    = (ready_line.size() > 0);
        r.head_id       = (ready_line.size() > 0) ? ready_line[0].id : '0;
        r.ready_count   = 5'(ready_line.size());
        r.blocked_count = 5'(blocked_line.size());
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t mismatch %s: expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ready_line.delete();
            blocked_line.delete();
            owed_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t unexpected result word: ok %0h head_id %0h",
                             $time, ok, head_id);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("ok", 8'(want.ok), 8'(ok));
                    compare_field("found_queue", 8'(want.found_queue), 8'(found_queue));
                    compare_field("found_priority", 8'(want.found_priority),
                                  8'(found_priority));
                    compare_field("head_valid", 8'(want.head_valid), 8'(head_valid));
                    compare_field("head_id", want.head_id, head_id);
                    compare_field("ready_count", 8'(want.ready_count), 8'(ready_count));
                    compare_field("blocked_count", 8'(want.blocked_count),
                                  8'(blocked_count));
                end
            end
            if (in_valid && !in_stall)
                owed_results.push_back(predict_command(command, process_id, priority_req));
        end
        outstanding = owed_results.size();
    end

endmodule

[tb/tb_process_ready_blocked_queues_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_process_ready_blocked_queues_top
// Drives directed and random queue commands into the process queues with
// random gaps and output stalls, including a long receiver hold and pauses
// until all results are back. A checker beside the block predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_process_ready_blocked_queues_top;
    import prbq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int BLOCKS         = 25;
    localparam int BLOCK_WORDS    = 40;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [1:0] command      = CMD_INS_READY;
    logic [7:0] process_id   = '0;
    logic [3:0] priority_req = '0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       ok;
    logic [1:0] found_queue;
    logic [3:0] found_priority;
    logic       head_valid;
    logic [7:0] head_id;
    logic [4:0] ready_count;
    logic [4:0] blocked_count;
    int         mismatches;
    int         outstanding;
    int         idle_cycles  = 0;
    bit         hold_request = 1'b0;

    always #5 clk = ~clk;

    process_ready_blocked_queues_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .process_id     (process_id),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .found_queue    (found_queue),
        .found_priority (found_priority),
        .head_valid     (head_valid),
        .head_id        (head_id),
        .ready_count    (ready_count),
        .blocked_count  (blocked_count)
    );

    prbq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .process_id     (process_id),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .found_queue    (found_queue),
        .found_priority (found_priority),
        .head_valid     (head_valid),
        .head_id        (head_id),
        .ready_count    (ready_count),
        .blocked_count  (blocked_count),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic logic [1:0] pick_command(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                return (r < 45) ? CMD_INS_READY : (r < 80) ? CMD_INS_BLOCKED :
                       (r < 90) ? CMD_REMOVE : CMD_FIND;
            MIX_DRAIN:
                return (r < 15) ? CMD_INS_READY : (r < 25) ? CMD_INS_BLOCKED :
                       (r < 75) ? CMD_REMOVE : CMD_FIND;
            default:
                return (r < 25) ? CMD_INS_READY : (r < 50) ? CMD_INS_BLOCKED :
                       (r < 75) ? CMD_REMOVE : CMD_FIND;
        endcase
    endfunction

    // small id pool so that finds and removes mostly hit
    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 11));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] pick_priority();
        if ($urandom_range(0, 1) == 0)
            return 4'($urandom_range(6, 8));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] id,
                             input logic [3:0] pri);
        command      <= cmd;
        process_id   <= id;
        priority_req <= pri;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int rx_hold;
        int rx_phase;
        bit rx_quiet;
        rx_hold  = 0;
        rx_phase = 0;
        rx_quiet = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_phase == 0)
            begin
                rx_quiet = ($urandom_range(0, 3) == 0);
                rx_phase = $urandom_range(50, 300);
            end
            rx_phase--;
            if (hold_request)
            begin
                hold_request = 1'b0;
                rx_hold      = LONG_HOLD;
            end
            else if (rx_hold == 0 && !rx_quiet)
                rx_hold = gap_len();
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        mix_t mix;
        bit   tx_quiet;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // misses on empty queues, lone entry, ties, duplicates across queues
        send_word(CMD_FIND,        8'h00, 4'h0);
        send_word(CMD_REMOVE,      8'hff, 4'hf);
        send_word(CMD_INS_READY,   8'hff, 4'h0);
        send_word(CMD_REMOVE,      8'hff, 4'h0);
        send_word(CMD_INS_READY,   8'hff, 4'h0);
        send_word(CMD_INS_READY,   8'h00, 4'hf);
        send_word(CMD_INS_READY,   8'h05, 4'hf);
        send_word(CMD_INS_READY,   8'h55, 4'h7);
        send_word(CMD_INS_READY,   8'haa, 4'h7);
        send_word(CMD_INS_BLOCKED, 8'haa, 4'hf);
        send_word(CMD_INS_BLOCKED, 8'h33, 4'h0);
        send_word(CMD_FIND,        8'haa, 4'h0);
        send_word(CMD_REMOVE,      8'haa, 4'h0);
        send_word(CMD_FIND,        8'haa, 4'h0);
        send_word(CMD_REMOVE,      8'haa, 4'h0);
        send_word(CMD_FIND,        8'haa, 4'h0);
        send_word(CMD_REMOVE,      8'h00, 4'h0);
        send_word(CMD_REMOVE,      8'h05, 4'h0);
        send_word(CMD_FIND,        8'h33, 4'h0);
        send_word(CMD_REMOVE,      8'h33, 4'h0);
        send_word(CMD_REMOVE,      8'h99, 4'h0);
        drain_results();

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            mix      = mix_t'($urandom_range(0, 2));
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (blk == 2)
                hold_request = 1'b1;
            for (int n = 0; n < BLOCK_WORDS; n++)
            begin
                send_word(pick_command(mix), pick_id(), pick_priority());
                if (!tx_quiet)
                    pause_sender(gap_len());
            end
            if (blk % 5 == 4)
                drain_results();
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
